// ----- rtl/button_click_event_detector_defines.svh -----
// Assertion macros shared by the checker of the button click event detector.
// Needs nothing else; every macro expands to one labelled concurrent assertion.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BCED_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BCED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bced_pkg.sv -----
// Package of the button click event detector: sizes, codes, types and helpers.
// Used by every module of the block but the RAM; depends on nothing.
package bced_pkg;

   localparam int NUM_KEYS    = 3;
   localparam int QUEUE_DEPTH = 8;

   localparam int CFG_W       = 16;
   localparam int ACTION_W    = 2;
   localparam int LEVEL_W     = 3;
   localparam int MODE_W      = 2;
   localparam int KEY_W       = 2;
   localparam int KIND_W      = 2;
   localparam int EVENT_W     = KEY_W + KIND_W;
   localparam int CSR_INDEX_W = 2;
   localparam int PHASE_W     = 2;
   localparam int KIDX_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_W-1:0] ACTION_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_POP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_CLEAR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LONG   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

   localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DEBOUNCE  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_PRESSED   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LONG_HELD = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_LIMIT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LIMIT      = 2'd2;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [CFG_W-1:0]   debounce_count;
      logic [CFG_W-1:0]   press_age;
      logic [CFG_W-1:0]   gap_count;
      logic               awaiting_second;
      logic               long_done;
   } key_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] long_limit;
      logic [CFG_W-1:0] gap_limit;
   } cfg_type;

   // Up to two events leave one key in one tick, in the order first then second.
   typedef struct packed {
      logic              first_push;
      logic [KIND_W-1:0] first_kind;
      logic              second_push;
      logic [KIND_W-1:0] second_kind;
   } key_push_type;

   function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] v);
      return (v == {CFG_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

// ----- rtl/bced_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the event queue storage.
module bced_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bced_key_unit.sv -----
// Shared key unit: one tick of one key's debounce, long press and click machine.
// Depends on bced_pkg for the state, configuration and event types.
module bced_key_unit (
   input  bced_pkg::key_state_type state_cur,
   input  logic                    level,
   input  bced_pkg::cfg_type       cfg,
   output bced_pkg::key_state_type state_nxt,
   output bced_pkg::key_push_type  push
);
   import bced_pkg::*;

   logic              short_fire;
   logic              late_push;
   logic [KIND_W-1:0] late_kind;
   logic [CFG_W-1:0]  gap_inc;
   logic [CFG_W-1:0]  deb_inc;
   logic [CFG_W-1:0]  hold_inc;

   always_comb begin
      state_nxt  = state_cur;
      short_fire = 1'b0;
      late_push  = 1'b0;
      late_kind  = KIND_SHORT;
      gap_inc    = sat_inc(state_cur.gap_count);
      deb_inc    = sat_inc(state_cur.debounce_count);
      hold_inc   = sat_inc(state_cur.press_age);

      // A pending short click times out before the phase is looked at.
      if (state_cur.awaiting_second) begin
         if (gap_inc > cfg.gap_limit) begin
            short_fire                = 1'b1;
            state_nxt.awaiting_second = 1'b0;
            state_nxt.gap_count       = '0;
         end else begin
            state_nxt.gap_count = gap_inc;
         end
      end

      case (state_cur.phase)
         PH_IDLE: begin
            if (!level) begin
               state_nxt.phase          = PH_DEBOUNCE;
               state_nxt.debounce_count = CFG_W'(1);
            end
         end
         PH_DEBOUNCE: begin
            if (!level) begin
               state_nxt.debounce_count = deb_inc;
               if (deb_inc >= cfg.debounce_ticks) begin
                  state_nxt.phase     = PH_PRESSED;
                  state_nxt.press_age = '0;
                  state_nxt.long_done = 1'b0;
               end
            end else begin
               state_nxt.phase          = PH_IDLE;
               state_nxt.debounce_count = '0;
            end
         end
         PH_PRESSED: begin
            if (!level) begin
               state_nxt.press_age = hold_inc;
               if (hold_inc >= cfg.long_limit && !state_cur.long_done) begin
                  late_push           = 1'b1;
                  late_kind           = KIND_LONG;
                  state_nxt.long_done = 1'b1;
                  state_nxt.phase     = PH_LONG_HELD;
               end
            end else begin
               if (state_nxt.awaiting_second) begin
                  late_push                 = 1'b1;
                  late_kind                 = KIND_DOUBLE;
                  state_nxt.awaiting_second = 1'b0;
               end else begin
                  state_nxt.awaiting_second = 1'b1;
               end
               state_nxt.gap_count = '0;
               state_nxt.phase     = PH_IDLE;
            end
         end
         default: begin
            // Releasing a long press drops any pending short click.
            if (level) begin
               state_nxt.phase           = PH_IDLE;
               state_nxt.awaiting_second = 1'b0;
               state_nxt.gap_count       = '0;
            end
         end
      endcase

      push.first_push  = short_fire | late_push;
      push.first_kind  = short_fire ? KIND_SHORT : late_kind;
      push.second_push = short_fire & late_push;
      push.second_kind = late_kind;
   end

endmodule

// ----- rtl/button_click_event_detector.sv -----
// Button click event detector. A tick item (action 0) runs every key in turn through
// one shared key unit, one key a cycle, with a pass through S_PUSH2 for a key that
// raises two events in the same tick, since the event queue RAM has a single write
// port. A pop with a non-empty queue passes through S_POP, which takes the registered
// RAM read, and then S_DONE; clear, an unused action or a pop of an empty queue goes
// straight to S_DONE. One item is in work at a time; the result register lets the
// next item be taken while the previous result waits. The queue holds QUEUE_DEPTH
// events and overwrites its oldest one when full. No clearing pass is needed after
// reset.
module button_click_event_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bced_pkg::ACTION_W-1:0]      req_action,
   input  logic [bced_pkg::LEVEL_W-1:0]       req_key_levels,
   input  logic [bced_pkg::MODE_W-1:0]        req_switch_mode,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_event_valid,
   output logic [bced_pkg::KEY_W-1:0]         rsp_event_key,
   output logic [bced_pkg::KIND_W-1:0]        rsp_event_kind,
   output logic [bced_pkg::COUNT_W-1:0]       rsp_queue_count,
   output logic [bced_pkg::MODE_W-1:0]        rsp_mode_value,
   output logic                               rsp_mode_changed,
   input  logic                               csr_write_enable,
   input  logic [bced_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bced_pkg::CFG_W-1:0]         csr_write_data
);
   import bced_pkg::*;

   localparam int LVL_PAD_W = NUM_KEYS + LEVEL_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_KEY   = 3'd1;
   localparam logic [2:0] S_PUSH2 = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [KIDX_W-1:0]  key_idx_ff, key_idx_in;
   logic [LEVEL_W-1:0] levels_ff, levels_in;
   logic [KIND_W-1:0]  pend_kind_ff, pend_kind_in;
   key_state_type      key_state_ff [NUM_KEYS];
   key_state_type      key_state_in [NUM_KEYS];
   cfg_type            cfg_ff, cfg_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [MODE_W-1:0]  prev_mode_ff, prev_mode_in;
   logic               mode_seen_ff, mode_seen_in;

   logic               res_valid_ff, res_valid_in;
   logic [KEY_W-1:0]   res_key_ff, res_key_in;
   logic [KIND_W-1:0]  res_kind_ff, res_kind_in;
   logic               res_changed_ff, res_changed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_event_valid_ff, rsp_event_valid_in;
   logic [KEY_W-1:0]   rsp_event_key_ff, rsp_event_key_in;
   logic [KIND_W-1:0]  rsp_event_kind_ff, rsp_event_kind_in;
   logic [COUNT_W-1:0] rsp_queue_count_ff, rsp_queue_count_in;
   logic [MODE_W-1:0]  rsp_mode_value_ff, rsp_mode_value_in;
   logic               rsp_mode_changed_ff, rsp_mode_changed_in;

   logic [LVL_PAD_W-1:0] levels_pad;
   logic [NUM_KEYS-1:0]  key_level_vec;
   logic                 key_level;
   key_state_type        unit_state_cur;
   key_state_type        unit_state_nxt;
   key_push_type         unit_push;

   logic                 push_en;
   logic [KIND_W-1:0]    push_kind;
   logic [EVENT_W-1:0]   push_data;
   logic [EVENT_W-1:0]   ram_rd_data;
   logic                 last_key;
   logic                 req_xfer;

   // Keys beyond the key level field see a low level, that is, pressed.
   assign levels_pad     = {{NUM_KEYS{1'b0}}, levels_ff};
   assign key_level_vec  = levels_pad[NUM_KEYS-1:0];
   assign key_level      = key_level_vec[key_idx_ff];
   assign unit_state_cur = key_state_ff[key_idx_ff];
   assign last_key       = (key_idx_ff == KIDX_W'(NUM_KEYS - 1));
   assign req_ready      = (state_ff == S_IDLE);
   assign req_xfer       = req_valid && req_ready;
   assign push_data      = {KEY_W'(key_idx_ff), push_kind};

   bced_key_unit u_key_unit (
      .state_cur (unit_state_cur),
      .level     (key_level),
      .cfg       (cfg_ff),
      .state_nxt (unit_state_nxt),
      .push      (unit_push)
   );

   bced_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in            = state_ff;
      key_idx_in          = key_idx_ff;
      levels_in           = levels_ff;
      pend_kind_in        = pend_kind_ff;
      key_state_in        = key_state_ff;
      cfg_in              = cfg_ff;
      wr_ptr_in           = wr_ptr_ff;
      rd_ptr_in           = rd_ptr_ff;
      count_in            = count_ff;
      prev_mode_in        = prev_mode_ff;
      mode_seen_in        = mode_seen_ff;
      res_valid_in        = res_valid_ff;
      res_key_in          = res_key_ff;
      res_kind_in         = res_kind_ff;
      res_changed_in      = res_changed_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_event_valid_in  = rsp_event_valid_ff;
      rsp_event_key_in    = rsp_event_key_ff;
      rsp_event_kind_in   = rsp_event_kind_ff;
      rsp_queue_count_in  = rsp_queue_count_ff;
      rsp_mode_value_in   = rsp_mode_value_ff;
      rsp_mode_changed_in = rsp_mode_changed_ff;
      push_en             = 1'b0;
      push_kind           = KIND_SHORT;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_write_data;
            CSR_LONG_LIMIT:     cfg_in.long_limit     = csr_write_data;
            CSR_GAP_LIMIT:      cfg_in.gap_limit      = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               levels_in      = req_key_levels;
               key_idx_in     = '0;
               res_valid_in   = 1'b0;
               res_key_in     = '0;
               res_kind_in    = KIND_SHORT;
               res_changed_in = 1'b0;
               state_in       = S_DONE;
               case (req_action)
                  ACTION_TICK: begin
                     res_changed_in = mode_seen_ff && (req_switch_mode != prev_mode_ff);
                     prev_mode_in   = req_switch_mode;
                     mode_seen_in   = 1'b1;
                     state_in       = S_KEY;
                  end
                  ACTION_POP: begin
                     if (count_ff != '0) begin
                        state_in = S_POP;
                     end
                  end
                  ACTION_CLEAR: begin
                     wr_ptr_in = '0;
                     rd_ptr_in = '0;
                     count_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_KEY: begin
            key_state_in[key_idx_ff] = unit_state_nxt;
            push_en                  = unit_push.first_push;
            push_kind                = unit_push.first_kind;
            pend_kind_in             = unit_push.second_kind;
            if (unit_push.second_push) begin
               state_in = S_PUSH2;
            end else if (last_key) begin
               state_in = S_DONE;
            end else begin
               key_idx_in = key_idx_ff + 1'b1;
            end
         end
         S_PUSH2: begin
            push_en   = 1'b1;
            push_kind = pend_kind_ff;
            if (last_key) begin
               state_in = S_DONE;
            end else begin
               key_idx_in = key_idx_ff + 1'b1;
               state_in   = S_KEY;
            end
         end
         S_POP: begin
            // The RAM has been reading the head entry since the transfer cycle.
            res_valid_in = 1'b1;
            res_key_in   = ram_rd_data[EVENT_W-1:KIND_W];
            res_kind_in  = ram_rd_data[KIND_W-1:0];
            rd_ptr_in    = ptr_inc(rd_ptr_ff);
            count_in     = count_ff - 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_event_valid_in  = res_valid_ff;
               rsp_event_key_in    = res_key_ff;
               rsp_event_kind_in   = res_kind_ff;
               rsp_queue_count_in  = count_ff;
               rsp_mode_value_in   = prev_mode_ff;
               rsp_mode_changed_in = res_changed_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // A full queue loses its oldest event to make room for the new one.
      if (push_en) begin
         wr_ptr_in = ptr_inc(wr_ptr_ff);
         if (count_ff == COUNT_W'(QUEUE_DEPTH)) begin
            rd_ptr_in = ptr_inc(rd_ptr_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= S_IDLE;
         key_idx_ff               <= '0;
         cfg_ff.debounce_ticks    <= CFG_W'(2);
         cfg_ff.long_limit        <= CFG_W'(10);
         cfg_ff.gap_limit         <= CFG_W'(3);
         wr_ptr_ff                <= '0;
         rd_ptr_ff                <= '0;
         count_ff                 <= '0;
         prev_mode_ff             <= '0;
         mode_seen_ff             <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_state_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         key_idx_ff   <= key_idx_in;
         cfg_ff       <= cfg_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         prev_mode_ff <= prev_mode_in;
         mode_seen_ff <= mode_seen_in;
         rsp_valid_ff <= rsp_valid_in;
         key_state_ff <= key_state_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff           <= levels_in;
      pend_kind_ff        <= pend_kind_in;
      res_valid_ff        <= res_valid_in;
      res_key_ff          <= res_key_in;
      res_kind_ff         <= res_kind_in;
      res_changed_ff      <= res_changed_in;
      rsp_event_valid_ff  <= rsp_event_valid_in;
      rsp_event_key_ff    <= rsp_event_key_in;
      rsp_event_kind_ff   <= rsp_event_kind_in;
      rsp_queue_count_ff  <= rsp_queue_count_in;
      rsp_mode_value_ff   <= rsp_mode_value_in;
      rsp_mode_changed_ff <= rsp_mode_changed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_valid  = rsp_event_valid_ff;
   assign rsp_event_key    = rsp_event_key_ff;
   assign rsp_event_kind   = rsp_event_kind_ff;
   assign rsp_queue_count  = rsp_queue_count_ff;
   assign rsp_mode_value   = rsp_mode_value_ff;
   assign rsp_mode_changed = rsp_mode_changed_ff;

endmodule

// ----- rtl/bced_checker.sv -----
// Port-level checker of the button click event detector, bound to the top level.
// Depends on bced_pkg and on the assertion macros in the defines header.
`include "button_click_event_detector_defines.svh"

module bced_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_event_valid,
   input logic [bced_pkg::KEY_W-1:0]         rsp_event_key,
   input logic [bced_pkg::KIND_W-1:0]        rsp_event_kind,
   input logic [bced_pkg::COUNT_W-1:0]       rsp_queue_count
);
   import bced_pkg::*;

   // Only one item is in work, so a transfer always drops ready in the cycle after it.
   `BCED_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready,
      "ready after transfer")

   `BCED_ASSERT_SAME(a_empty_pop, clock, reset, rsp_valid && !rsp_event_valid,
      rsp_event_key == '0 && rsp_event_kind == KIND_SHORT, "stale event fields")

   `BCED_ASSERT_SAME(a_kind_code, clock, reset, rsp_valid && rsp_event_valid,
      rsp_event_kind <= KIND_DOUBLE, "unknown event kind")

   `BCED_ASSERT_SAME(a_count_max, clock, reset, rsp_valid,
      rsp_queue_count <= COUNT_W'(QUEUE_DEPTH), "queue count too high")

   `BCED_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_queue_count) && $stable(rsp_event_valid),
      "result changed while stalled")

endmodule

bind button_click_event_detector bced_checker u_bced_checker (.*);

// ----- sim/button_click_event_detector_tb.sv -----
// Self-checking testbench of the button click event detector: directed and random key
// traffic under several settings, checked transfer by transfer against a local predictor.
// Depends on bced_pkg and the button_click_event_detector RTL only.
module button_click_event_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bced_pkg::*;

   // The fourth action code has no name in the package; the block must ignore it.
   localparam logic [ACTION_W-1:0] ACTION_UNUSED = 2'd3;

   typedef struct packed {
      logic               event_valid;
      logic [KEY_W-1:0]   event_key;
      logic [KIND_W-1:0]  event_kind;
      logic [COUNT_W-1:0] queue_count;
      logic [MODE_W-1:0]  mode_value;
      logic               mode_changed;
   } detector_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ACTION_W-1:0]    req_action = '0;
   logic [LEVEL_W-1:0]     req_key_levels = '1;
   logic [MODE_W-1:0]      req_switch_mode = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_event_valid;
   logic [KEY_W-1:0]       rsp_event_key;
   logic [KIND_W-1:0]      rsp_event_kind;
   logic [COUNT_W-1:0]     rsp_queue_count;
   logic [MODE_W-1:0]      rsp_mode_value;
   logic                   rsp_mode_changed;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_write_data = '0;

   button_click_event_detector dut (.*);

   always #1 clock = ~clock;

   // Settings as the block should hold them.
   logic [CFG_W-1:0] cfg_debounce = 16'd2;
   logic [CFG_W-1:0] cfg_long = 16'd10;
   logic [CFG_W-1:0] cfg_gap = 16'd3;

   // Predicted state of every key and of the event ring.
   logic [PHASE_W-1:0] pk_phase [NUM_KEYS] = '{default: PH_IDLE};
   logic [CFG_W-1:0]   pk_debounce [NUM_KEYS] = '{default: '0};
   logic [CFG_W-1:0]   pk_hold [NUM_KEYS] = '{default: '0};
   logic [CFG_W-1:0]   pk_gap [NUM_KEYS] = '{default: '0};
   logic               pk_waiting [NUM_KEYS] = '{default: 1'b0};
   logic               pk_long_fired [NUM_KEYS] = '{default: 1'b0};
   logic [EVENT_W-1:0] event_ring [QUEUE_DEPTH];
   int                 ring_wr = 0;
   int                 ring_rd = 0;
   int                 ring_count = 0;
   logic [MODE_W-1:0]  last_mode = '0;
   logic               mode_known = 1'b0;

   detector_result_type expected_results [$];
   int                 failures = 0;
   bit                 idle_on = 1'b1;
   int                 rsp_hold_cycles = 0;
   logic [LEVEL_W-1:0] held_levels = '1;
   logic [MODE_W-1:0]  current_mode = '0;

   function automatic logic [CFG_W-1:0] count_up(input logic [CFG_W-1:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   function automatic void queue_event(input logic [KEY_W-1:0] key,
                                       input logic [KIND_W-1:0] kind);
      // A full ring loses its oldest event to make room.
      if (ring_count == QUEUE_DEPTH) begin
         ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
         ring_count--;
      end
      event_ring[ring_wr] = {key, kind};
      ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
      ring_count++;
   endfunction

   function automatic void advance_key(input int k, input logic level);
      // A pending short click times out before the key's own phase is looked at.
      if (pk_waiting[k]) begin
         pk_gap[k] = count_up(pk_gap[k]);
         if (pk_gap[k] > cfg_gap) begin
            queue_event(KEY_W'(k), KIND_SHORT);
            pk_waiting[k] = 1'b0;
            pk_gap[k] = '0;
         end
      end
      case (pk_phase[k])
         PH_IDLE: begin
            if (!level) begin
               pk_phase[k] = PH_DEBOUNCE;
               pk_debounce[k] = 16'd1;
            end
         end
         PH_DEBOUNCE: begin
            if (!level) begin
               pk_debounce[k] = count_up(pk_debounce[k]);
               if (pk_debounce[k] >= cfg_debounce) begin
                  pk_phase[k] = PH_PRESSED;
                  pk_hold[k] = '0;
                  pk_long_fired[k] = 1'b0;
               end
            end else begin
               pk_phase[k] = PH_IDLE;
               pk_debounce[k] = '0;
            end
         end
         PH_PRESSED: begin
            if (!level) begin
               pk_hold[k] = count_up(pk_hold[k]);
               if (pk_hold[k] >= cfg_long && !pk_long_fired[k]) begin
                  queue_event(KEY_W'(k), KIND_LONG);
                  pk_long_fired[k] = 1'b1;
                  pk_phase[k] = PH_LONG_HELD;
               end
            end else begin
               if (pk_waiting[k]) begin
                  queue_event(KEY_W'(k), KIND_DOUBLE);
                  pk_waiting[k] = 1'b0;
               end else begin
                  pk_waiting[k] = 1'b1;
               end
               pk_gap[k] = '0;
               pk_phase[k] = PH_IDLE;
            end
         end
         default: begin
            // Releasing a long press also drops any short click still pending.
            if (level) begin
               pk_phase[k] = PH_IDLE;
               pk_waiting[k] = 1'b0;
               pk_gap[k] = '0;
            end
         end
      endcase
   endfunction

   function automatic detector_result_type predict_outcome(
         input logic [ACTION_W-1:0] action,
         input logic [LEVEL_W-1:0] levels,
         input logic [MODE_W-1:0] mode);
      detector_result_type r;
      logic [EVENT_W-1:0] e;
      r = '0;
      case (action)
         ACTION_TICK: begin
            for (int k = 0; k < NUM_KEYS; k++)
               advance_key(k, (k < LEVEL_W) ? levels[k] : 1'b0);
            r.mode_changed = mode_known && (mode != last_mode);
            last_mode = mode;
            mode_known = 1'b1;
         end
         ACTION_POP: begin
            if (ring_count != 0) begin
               e = event_ring[ring_rd];
               r.event_valid = 1'b1;
               r.event_key = e[EVENT_W-1:KIND_W];
               r.event_kind = e[KIND_W-1:0];
               ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
               ring_count--;
            end
         end
         ACTION_CLEAR: begin
            ring_wr = 0;
            ring_rd = 0;
            ring_count = 0;
         end
         default: ;
      endcase
      r.queue_count = COUNT_W'(ring_count);
      r.mode_value = last_mode;
      return r;
   endfunction

   function automatic void note_failure(input string what, input int want, input int got);
      failures++;
      if (failures <= 10)
         $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
   endfunction

   // Offers one item, holding valid and payload until the transfer, then predicts it.
   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic [LEVEL_W-1:0] levels,
                            input logic [MODE_W-1:0] mode);
      while (idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_key_levels <= levels;
      req_switch_mode <= mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_outcome(action, levels, mode));
   endtask

   task automatic tick(input logic [LEVEL_W-1:0] levels, input logic [MODE_W-1:0] mode);
      send_item(ACTION_TICK, levels, mode);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CFG_W-1:0] debounce,
                                 input logic [CFG_W-1:0] hold,
                                 input logic [CFG_W-1:0] gap);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_DEBOUNCE_TICKS;
      csr_write_data <= debounce;
      @(posedge clock);
      csr_index <= CSR_LONG_LIMIT;
      csr_write_data <= hold;
      @(posedge clock);
      csr_index <= CSR_GAP_LIMIT;
      csr_write_data <= gap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_debounce = debounce;
      cfg_long = hold;
      cfg_gap = gap;
   endtask

   // Keys mostly keep their level for a while so that real presses and clicks form;
   // a few ticks carry arbitrary levels, and pops, clears and unused codes are mixed in.
   task automatic random_traffic(input int count, input int pop_pct, input int toggle_pct);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < pop_pct) begin
            send_item(ACTION_POP, LEVEL_W'($urandom), MODE_W'($urandom));
         end else if (pick < pop_pct + 3) begin
            send_item(ACTION_CLEAR, LEVEL_W'($urandom), MODE_W'($urandom));
         end else if (pick < pop_pct + 5) begin
            send_item(ACTION_UNUSED, LEVEL_W'($urandom), MODE_W'($urandom));
         end else begin
            if ($urandom_range(99) < 5) begin
               held_levels = LEVEL_W'($urandom);
            end else begin
               for (int k = 0; k < LEVEL_W; k++)
                  if ($urandom_range(99) < toggle_pct) held_levels[k] = ~held_levels[k];
            end
            if ($urandom_range(99) < 6) current_mode = MODE_W'($urandom);
            tick(held_levels, current_mode);
         end
      end
   endtask

   task automatic test_directed_basics();
      // First tick only records the mode; a later change gives one pulse.
      tick(3'b111, 2'd2);
      tick(3'b111, 2'd2);
      tick(3'b111, 2'd1);
      send_item(ACTION_UNUSED, 3'b000, 2'd3);
      send_item(ACTION_POP, 3'b101, 2'd0);
      send_item(ACTION_CLEAR, 3'b010, 2'd3);
      // Key 0: two clicks within the gap make a double click.
      tick(3'b110, 2'd1);
      tick(3'b110, 2'd1);
      tick(3'b111, 2'd1);
      tick(3'b110, 2'd1);
      tick(3'b110, 2'd1);
      tick(3'b111, 2'd1);
      // Key 1: a single click that times out into a short click.
      tick(3'b101, 2'd3);
      tick(3'b101, 2'd3);
      tick(3'b111, 2'd3);
      repeat (4) tick(3'b111, 2'd3);
      send_item(ACTION_POP, 3'b111, 2'd0);
      send_item(ACTION_POP, 3'b000, 2'd3);
      tick(3'b000, 2'd0);
      tick(3'b011, 2'd0);
      send_item(ACTION_CLEAR, 3'b111, 2'd0);
   endtask

   task automatic test_reset_settings_traffic();
      random_traffic(120, 15, 25);
   endtask

   task automatic test_shortest_settings();
      // One-tick debounce, immediate long press and no gap; rare pops overflow the ring.
      write_settings(16'd1, 16'd1, 16'd0);
      random_traffic(120, 5, 30);
   endtask

   task automatic test_long_holds();
      // Long gap lets a long press fire in the same tick as a pending short click, short first.
      write_settings(16'd3, 16'd6, 16'd8);
      random_traffic(120, 20, 12);
   endtask

   task automatic test_largest_settings();
      write_settings(16'd1, 16'hFFFF, 16'hFFFE);
      random_traffic(100, 25, 25);
      write_settings(16'hFFFF, 16'd1, 16'd0);
      random_traffic(60, 40, 25);
   endtask

   task automatic test_back_to_back();
      write_settings(16'd2, 16'd4, 16'd2);
      idle_on = 1'b0;
      random_traffic(150, 20, 20);
      idle_on = 1'b1;
   endtask

   task automatic test_output_stall();
      // The result side stops for a long stretch while items keep coming, so the
      // block fills and has to hold its input off.
      write_settings(16'd1, 16'd3, 16'd1);
      rsp_hold_cycles = 300;
      random_traffic(40, 20, 25);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         write_settings(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 8)),
                        CFG_W'($urandom_range(0, 6)));
         random_traffic(40, 18, 20);
      end
   endtask

   // Result side: random back-pressure, plus the long hold-off when one is asked for.
   always @(posedge clock) begin : result_side
      detector_result_type want;
      detector_result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_event_valid, rsp_event_key, rsp_event_kind, rsp_queue_count,
                   rsp_mode_value, rsp_mode_changed};
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t ns: result transfer with nothing expected", $time);
            end else begin
               want = expected_results.pop_front();
               if (got.event_valid !== want.event_valid)
                  note_failure("event_valid", want.event_valid, got.event_valid);
               if (got.event_key !== want.event_key)
                  note_failure("event_key", want.event_key, got.event_key);
               if (got.event_kind !== want.event_kind)
                  note_failure("event_kind", want.event_kind, got.event_kind);
               if (got.queue_count !== want.queue_count)
                  note_failure("queue_count", want.queue_count, got.queue_count);
               if (got.mode_value !== want.mode_value)
                  note_failure("mode_value", want.mode_value, got.mode_value);
               if (got.mode_changed !== want.mode_changed)
                  note_failure("mode_changed", want.mode_changed, got.mode_changed);
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 14);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_reset_settings_traffic();
      test_shortest_settings();
      test_long_holds();
      test_largest_settings();
      test_back_to_back();
      test_output_stall();
      test_random_settings();
      wait_for_drain();
      // Give a stray extra result time to show up.
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("button_click_event_detector_tb: PASS");
      else
         $display("button_click_event_detector_tb: FAIL");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("button_click_event_detector_tb: FAIL");
      $finish;
   end

endmodule
